>>> hw/rtl/css_pkg.sv
// package for the color signature similarity unit
// shared widths, entry and command types and reset threshold; no dependencies
package css_pkg;
  localparam int Entries = 8;
  localparam int IdxW = (Entries > 1) ? $clog2(Entries) : 1;
  localparam int CntW = $clog2(Entries + 1);
  localparam int TotW = 16 + CntW;
  localparam logic [15:0] ThreshReset = 16'd6554;

  typedef struct packed {
    logic [15:0] weight;
    logic [15:0] red;
    logic [15:0] green;
    logic [15:0] blue;
  } entry_t;

  typedef struct packed {
    logic       last;
    logic [1:0] empty;
  } cmd_t;
endpackage

>>> hw/rtl/color_signature_similarity_unit.sv
// top level of the color signature similarity unit
// depends on css_pkg, css_front, css_back, css_isqrt
//
// channel   direction  signals
// cmd       in         start_i, busy_o, set_sel_i .. last_i
// result    out        result_strobe_o, similarity_o, valid_res_o
// config    in         cfg_we_i, cfg_wdata_i
//
// a beat without last stores its entry; a beat with last starts the compare
// compare: loads every entry, takes the norm of each, then tests every pair both ways
// an invalid compare skips the pairs and the division and returns zero
// busy_o is high while a command is queued or the back end works
// reset clears control and presets threshold; entry stores undefined until written
module color_signature_similarity_unit (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start_i,
  output logic        busy_o,
  input  logic        set_sel_i,
  input  logic [2:0]  slot_i,
  input  logic [15:0] weight_i,
  input  logic [15:0] red_i,
  input  logic [15:0] green_i,
  input  logic [15:0] blue_i,
  input  logic        sig_empty_i,
  input  logic        last_i,
  input  logic        cfg_we_i,
  input  logic [15:0] cfg_wdata_i,
  output logic        result_strobe_o,
  output logic [16:0] similarity_o,
  output logic        valid_res_o
);
  import css_pkg::*;
  logic [15:0] thresh_q;
  logic cmd_valid, cmd_pop, back_busy, rd_set;
  cmd_t cmd;
  logic [IdxW-1:0] rd_idx;
  entry_t rd_data;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      thresh_q <= ThreshReset;
    end else if (cfg_we_i) begin
      thresh_q <= cfg_wdata_i;
    end
  end

  css_front u_front (.clk_i, .rst_ni, .start_i, .set_sel_i, .slot_i,
    .entry_i('{weight: weight_i, red: red_i, green: green_i, blue: blue_i}),
    .sig_empty_i, .last_i, .back_busy_i(back_busy), .cmd_pop_i(cmd_pop),
    .rd_set_i(rd_set), .rd_idx_i(rd_idx), .rd_data_o(rd_data),
    .cmd_valid_o(cmd_valid), .cmd_o(cmd), .busy_o);

  css_back u_back (.clk_i, .rst_ni, .thresh_i(thresh_q), .cmd_valid_i(cmd_valid),
    .cmd_i(cmd), .cmd_pop_o(cmd_pop), .rd_set_o(rd_set), .rd_idx_o(rd_idx),
    .rd_data_i(rd_data), .busy_o(back_busy), .res_stb_o(result_strobe_o),
    .similarity_o, .valid_res_o);

`ifndef SYNTHESIS
  a_no_accept_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_valid |-> busy_o) else $error("queued command not blocking");
  a_sim_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_strobe_o |-> similarity_o <= 17'd65536) else $error("similarity range");
  a_invalid_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_strobe_o && !valid_res_o |-> similarity_o == 17'd0)
    else $error("invalid result nonzero");
`endif
endmodule

>>> hw/rtl/css_isqrt.sv
// multicycle integer square root; a start while busy restarts the computation
// depends on css_pkg
module css_isqrt (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start_i,
  input  logic [49:0] val_i,
  output logic        done_o,
  output logic [24:0] root_o
);
  import css_pkg::*;
  logic [51:0] rem_q, rem_d;
  logic [51:0] res_q, res_d;
  logic [51:0] bit_q, bit_d;
  logic        busy_q, busy_d;
  logic [51:0] trial;

  always_comb begin
    rem_d = rem_q; res_d = res_q; bit_d = bit_q; busy_d = busy_q;
    trial = res_q + bit_q;
    done_o = 1'b0;
    if (start_i) begin
      rem_d = {2'd0, val_i}; res_d = '0; bit_d = 52'd1 << 50; busy_d = 1'b1;
    end else if (busy_q) begin
      if (rem_q >= trial) begin
        rem_d = rem_q - trial;
        res_d = (res_q >> 1) + bit_q;
      end else begin
        res_d = res_q >> 1;
      end
      bit_d = bit_q >> 2;
      if (bit_q[0]) begin
        busy_d = 1'b0;
        done_o = 1'b1;
      end
    end
  end
  assign root_o = res_d[24:0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
    end else begin
      busy_q <= busy_d;
    end
  end
  always_ff @(posedge clk_i) begin
    rem_q <= rem_d; res_q <= res_d; bit_q <= bit_d;
  end
endmodule

>>> hw/rtl/css_front.sv
// front end: stores entries, tracks empty flags, queues compare commands
// depends on css_pkg
module css_front (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  start_i,
  input  logic                  set_sel_i,
  input  logic [2:0]            slot_i,
  input  css_pkg::entry_t       entry_i,
  input  logic                  sig_empty_i,
  input  logic                  last_i,
  input  logic                  back_busy_i,
  input  logic                  cmd_pop_i,
  input  logic                  rd_set_i,
  input  logic [css_pkg::IdxW-1:0] rd_idx_i,
  output css_pkg::entry_t       rd_data_o,
  output logic                  cmd_valid_o,
  output css_pkg::cmd_t         cmd_o,
  output logic                  busy_o
);
  import css_pkg::*;
  entry_t     store_a [Entries];
  entry_t     store_b [Entries];
  logic [1:0] empty_q, empty_d;
  logic       qv_q;
  cmd_t       qcmd_q;
  logic       acc;

  assign busy_o = qv_q || back_busy_i;
  assign acc = start_i && !busy_o;

  always_comb begin
    empty_d = empty_q;
    if (acc) empty_d[set_sel_i] = sig_empty_i;
  end

  always_ff @(posedge clk_i) begin
    if (acc && (32'(slot_i) < Entries)) begin
      if (set_sel_i) store_b[IdxW'(slot_i)] <= entry_i;
      else store_a[IdxW'(slot_i)] <= entry_i;
    end
    rd_data_o <= rd_set_i ? store_b[rd_idx_i] : store_a[rd_idx_i];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      empty_q <= '0;
      qv_q    <= 1'b0;
      qcmd_q  <= '0;
    end else begin
      empty_q <= empty_d;
      if (acc && last_i) begin
        qv_q   <= 1'b1;
        qcmd_q <= '{last: 1'b1, empty: empty_d};
      end else if (cmd_pop_i) begin
        qv_q <= 1'b0;
      end
    end
  end
  assign cmd_valid_o = qv_q;
  assign cmd_o = qcmd_q;
endmodule

>>> hw/rtl/css_back.sv
// back end: precomputes norms, walks all pairs both ways, divides scores
// depends on css_pkg and css_isqrt
module css_back (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic [15:0]           thresh_i,
  input  logic                  cmd_valid_i,
  input  css_pkg::cmd_t         cmd_i,
  output logic                  cmd_pop_o,
  output logic                  rd_set_o,
  output logic [css_pkg::IdxW-1:0] rd_idx_o,
  input  css_pkg::entry_t       rd_data_i,
  output logic                  busy_o,
  output logic                  res_stb_o,
  output logic [16:0]           similarity_o,
  output logic                  valid_res_o
);
  import css_pkg::*;
  localparam logic [3:0] SIdle = 4'd0, SLoad = 4'd1, SLoadW = 4'd2, SNorm = 4'd3,
    SNormW = 4'd4, SPair = 4'd5, SPairD = 4'd6, SPairW = 4'd7, SCmp = 4'd8,
    SDivA = 4'd9, SDivB = 4'd10, SOut = 4'd11, SNormD = 4'd12;
  logic [3:0] st_q;
  logic [1:0] empty_q;
  entry_t     ea [Entries];
  entry_t     eb [Entries];
  logic [24:0] na [Entries];
  logic [24:0] nb [Entries];
  logic        ldset_q, dir_q;
  logic [IdxW-1:0] i_q, j_q;
  logic [TotW-1:0] tot_a_q, tot_b_q, acc_q, sab_q, sba_q;
  entry_t pp, qq;
  logic [24:0] np, nq;
  logic [49:0] sq_d;
  logic [16:0] dch [3];
  logic [33:0] sq_q [3];
  logic        sq_start, sq_done;
  logic [49:0] sq_val;
  logic [24:0] sq_root;
  logic [41:0] lhs;
  logic [41:0] rhs_q;
  logic        mt_q;
  logic [TotW-1:0] accn;
  logic [15:0] pw;
  // divider
  logic [TotW+16:0] rem_q;
  logic [16:0] quo_q, ra_q, qnext;
  logic [4:0]  dc_q;
  logic [TotW:0] dtrial;
  logic [TotW-1:0] den;

  css_isqrt u_sqrt (.clk_i, .rst_ni, .start_i(sq_start), .val_i(sq_val),
    .done_o(sq_done), .root_o(sq_root));

  assign pp = dir_q ? eb[i_q] : ea[i_q];
  assign qq = dir_q ? ea[j_q] : eb[j_q];
  assign np = dir_q ? nb[i_q] : na[i_q];
  assign nq = dir_q ? na[j_q] : nb[j_q];
  assign pw = pp.weight;
  always_comb begin
    dch[0] = {1'b0, pp.red} - {1'b0, qq.red};
    dch[1] = {1'b0, pp.green} - {1'b0, qq.green};
    dch[2] = {1'b0, pp.blue} - {1'b0, qq.blue};
    for (int k = 0; k < 3; k++) if (dch[k][16]) dch[k] = 17'(-dch[k]);
  end
  assign sq_d = {16'(0), sq_q[0]} + {16'(0), sq_q[1]} + {16'(0), sq_q[2]};
  assign sq_start = (st_q == SNormD) || (st_q == SPairD);
  assign sq_val = sq_d << 16;
  assign lhs = {1'b0, sq_root, 16'd0};
  assign accn = acc_q + (mt_q ? TotW'(qq.weight) : '0);
  assign den = (st_q == SDivA) ? tot_a_q : tot_b_q;
  assign dtrial = {rem_q[TotW+15:16], rem_q[15]} - {1'b0, den};
  assign qnext = {quo_q[15:0], !dtrial[TotW]};
  assign cmd_pop_o = (st_q == SIdle) && cmd_valid_i;
  assign busy_o = (st_q != SIdle);
  assign rd_set_o = ldset_q;
  assign rd_idx_o = i_q;

  always_ff @(posedge clk_i) begin
    case (st_q)
      SLoadW: begin
        if (ldset_q) eb[i_q] <= rd_data_i; else ea[i_q] <= rd_data_i;
        if (ldset_q) tot_b_q <= tot_b_q + TotW'(rd_data_i.weight);
        else tot_a_q <= tot_a_q + TotW'(rd_data_i.weight);
      end
      SNorm: begin
        sq_q[0] <= 34'(pp.red) * 34'(pp.red);
        sq_q[1] <= 34'(pp.green) * 34'(pp.green);
        sq_q[2] <= 34'(pp.blue) * 34'(pp.blue);
      end
      SNormW: if (sq_done) begin
        if (dir_q) nb[i_q] <= sq_root; else na[i_q] <= sq_root;
      end
      SPair: begin
        for (int k = 0; k < 3; k++) sq_q[k] <= 34'(dch[k]) * 34'(dch[k]);
        rhs_q <= 42'(thresh_i) * 42'({1'b0, np} + {1'b0, nq});
      end
      SPairW: if (sq_done) mt_q <= (rhs_q != 0) && (lhs < rhs_q);
      SCmp: begin
        acc_q <= (j_q == IdxW'(Entries - 1)) ? '0 : accn;
        if (j_q == IdxW'(Entries - 1)) begin
          if (dir_q) sba_q <= sba_q + ((accn < TotW'(pw)) ? accn : TotW'(pw));
          else sab_q <= sab_q + ((accn < TotW'(pw)) ? accn : TotW'(pw));
        end
        if (dir_q && i_q == IdxW'(Entries - 1) && j_q == IdxW'(Entries - 1)) begin
          rem_q <= {1'b0, sab_q, 16'd0} >> 1;
          quo_q <= '0;
        end
      end
      SDivA, SDivB: begin
        if (st_q == SDivA && dc_q == 5'd16) begin
          rem_q <= {1'b0, sba_q, 16'd0} >> 1;
          quo_q <= '0;
        end else if (!dtrial[TotW]) begin
          rem_q <= {1'b0, dtrial[TotW-1:0], rem_q[14:0], 1'b0};
          quo_q <= {quo_q[15:0], 1'b1};
        end else begin
          rem_q <= rem_q << 1;
          quo_q <= {quo_q[15:0], 1'b0};
        end
      end
      default: ;
    endcase
    if (st_q == SIdle) begin
      tot_a_q <= '0; tot_b_q <= '0; sab_q <= '0; sba_q <= '0; acc_q <= '0;
      empty_q <= cmd_i.empty;
    end
  end

  // sq input must be registered before start; norm and pair use two-step start
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q <= SIdle; i_q <= '0; j_q <= '0; ldset_q <= 1'b0; dir_q <= 1'b0;
      dc_q <= '0; res_stb_o <= 1'b0; similarity_o <= '0; valid_res_o <= 1'b0;
      ra_q <= '0;
    end else begin
      res_stb_o <= 1'b0;
      case (st_q)
        SIdle: if (cmd_valid_i && cmd_i.last) begin
          st_q <= SLoad; i_q <= '0; ldset_q <= 1'b0;
        end
        SLoad: st_q <= SLoadW;
        SLoadW: begin
          if (!ldset_q) begin
            ldset_q <= 1'b1; st_q <= SLoad;
          end else begin
            ldset_q <= 1'b0;
            if (i_q == IdxW'(Entries - 1)) begin
              i_q <= '0; st_q <= SNorm; dir_q <= 1'b0;
            end else begin
              i_q <= i_q + 1'b1; st_q <= SLoad;
            end
          end
        end
        SNorm: st_q <= SNormD;
        SNormD: st_q <= SNormW;
        SNormW: if (sq_done) begin
          if (!dir_q) begin
            dir_q <= 1'b1; st_q <= SNorm;
          end else begin
            dir_q <= 1'b0;
            if (i_q == IdxW'(Entries - 1)) begin
              if (empty_q != 0 || tot_a_q == 0 || tot_b_q == 0) begin
                st_q <= SOut; ra_q <= '0;
              end else begin
                i_q <= '0; j_q <= '0; st_q <= SPair;
              end
            end else begin
              i_q <= i_q + 1'b1; st_q <= SNorm;
            end
          end
        end
        SPair: st_q <= SPairD;
        SPairD: st_q <= SPairW;
        SPairW: if (sq_done) st_q <= SCmp;
        SCmp: begin
          st_q <= SPair;
          if (j_q == IdxW'(Entries - 1)) begin
            j_q <= '0;
            if (i_q == IdxW'(Entries - 1)) begin
              i_q <= '0;
              if (dir_q) begin
                st_q <= SDivA; dc_q <= '0;
              end else dir_q <= 1'b1;
            end else i_q <= i_q + 1'b1;
          end else j_q <= j_q + 1'b1;
        end
        SDivA, SDivB: begin
          dc_q <= dc_q + 1'b1;
          if (dc_q == 5'd16) begin
            dc_q <= '0;
            if (st_q == SDivA) begin
              st_q <= SDivB; ra_q <= qnext;
            end else begin
              st_q <= SOut;
              ra_q <= (qnext < ra_q) ? qnext : ra_q;
            end
          end
        end
        SOut: begin
          st_q <= SIdle; res_stb_o <= 1'b1;
          similarity_o <= ra_q;
          valid_res_o <= !(empty_q != 0 || tot_a_q == 0 || tot_b_q == 0);
        end
        default: st_q <= SIdle;
      endcase
    end
  end
endmodule

>>> bench/tb_color_signature_similarity_unit.sv
// testbench for color_signature_similarity_unit: loads signatures, predicts
// each similarity result and checks it on each result strobe; depends on css_pkg
`timescale 1ns / 1ps
module tb_color_signature_similarity_unit;
  import css_pkg::*;

  typedef struct {
    bit        sel;
    bit [2:0]  slot;
    bit [15:0] weight, red, green, blue;
    bit        empty, last;
  } beat_t;

  typedef struct {
    bit [16:0] sim;
    bit        ok;
  } score_t;

  class sim_scoreboard;
    entry_t     sig_a [Entries];
    entry_t     sig_b [Entries];
    bit [1:0]   empty_flags;
    bit [15:0]  threshold;
    score_t     expected_q[$];
    int         errors;

    function new();
      threshold = ThreshReset;
      empty_flags = 0;
      errors = 0;
    endfunction

    function bit [63:0] root_fx(bit [63:0] v);
      bit [63:0] r, b;
      r = 0;
      b = 64'd1 << 62;
      while (b > v) b >>= 2;
      while (b != 0) begin
        if (v >= r + b) begin
          v -= r + b;
          r = (r >> 1) + b;
        end else begin
          r >>= 1;
        end
        b >>= 2;
      end
      return r;
    endfunction

    function bit [63:0] magnitude(entry_t e);
      bit [63:0] s;
      s = 64'(e.red) * e.red + 64'(e.green) * e.green + 64'(e.blue) * e.blue;
      return root_fx(s << 16);
    endfunction

    function bit close_colors(entry_t p, entry_t q);
      bit [63:0] dr, dg, db, d, den;
      dr = p.red > q.red ? p.red - q.red : q.red - p.red;
      dg = p.green > q.green ? p.green - q.green : q.green - p.green;
      db = p.blue > q.blue ? p.blue - q.blue : q.blue - p.blue;
      d = root_fx((dr * dr + dg * dg + db * db) << 16);
      den = magnitude(p) + magnitude(q);
      if (den == 0) return 0;
      return (d << 16) < 64'(threshold) * den;
    endfunction

    function bit [63:0] covered_weight(entry_t x[Entries], entry_t y[Entries]);
      bit [63:0] score, acc;
      score = 0;
      for (int i = 0; i < Entries; i++) begin
        acc = 0;
        for (int j = 0; j < Entries; j++)
          if (close_colors(x[i], y[j])) acc += y[j].weight;
        score += acc < x[i].weight ? acc : 64'(x[i].weight);
      end
      return score;
    endfunction

    function void note_beat(beat_t t);
      entry_t    e;
      bit [63:0] tot_a, tot_b, ra, rb;
      score_t    s;
      e = {t.weight, t.red, t.green, t.blue};
      if (t.slot < Entries) begin
        if (t.sel) sig_b[t.slot] = e;
        else sig_a[t.slot] = e;
      end
      empty_flags[t.sel] = t.empty;
      if (!t.last) return;
      tot_a = 0;
      tot_b = 0;
      for (int i = 0; i < Entries; i++) begin
        tot_a += sig_a[i].weight;
        tot_b += sig_b[i].weight;
      end
      s.sim = 0;
      s.ok = 0;
      if (empty_flags == 0 && tot_a != 0 && tot_b != 0) begin
        ra = (covered_weight(sig_a, sig_b) << 16) / tot_a;
        rb = (covered_weight(sig_b, sig_a) << 16) / tot_b;
        s.sim = 17'(ra < rb ? ra : rb);
        s.ok = 1;
      end
      expected_q.push_back(s);
    endfunction

    function void check_result(bit [16:0] sim, bit ok);
      score_t s;
      if (expected_q.size() == 0) begin
        $display("%0t: unexpected result sim=%0d valid=%0d", $time, sim, ok);
        errors++;
        return;
      end
      s = expected_q.pop_front();
      if (s.sim != sim) begin
        $display("%0t: similarity expected %0d actual %0d", $time, s.sim, sim);
        errors++;
      end
      if (s.ok != ok) begin
        $display("%0t: valid_res expected %0d actual %0d", $time, s.ok, ok);
        errors++;
      end
    endfunction
  endclass

  logic        clk_i = 0;
  logic        rst_ni = 0;
  logic        start_i = 0;
  logic        busy_o;
  logic        set_sel_i = 0;
  logic [2:0]  slot_i = 0;
  logic [15:0] weight_i = 0, red_i = 0, green_i = 0, blue_i = 0;
  logic        sig_empty_i = 0;
  logic        last_i = 0;
  logic        cfg_we_i = 0;
  logic [15:0] cfg_wdata_i = 0;
  logic        result_strobe_o;
  logic [16:0] similarity_o;
  logic        valid_res_o;

  sim_scoreboard sb = new();
  int            quiet_cycles = 0;
  localparam int WatchLimit = 40000;

  color_signature_similarity_unit dut (.*);

  always begin
    #10 clk_i = 1;
    #10 clk_i = 0;
  end

  always @(posedge clk_i) begin
    if (rst_ni && result_strobe_o) sb.check_result(similarity_o, valid_res_o);
    if ((start_i && !busy_o) || result_strobe_o) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= WatchLimit) begin
      $display("simulation failed");
      $finish;
    end
  end

  task automatic send(beat_t t);
    int gap;
    gap = int'($urandom_range(0, 4));
    if (gap > 0) begin
      start_i <= 0;
      repeat (gap) @(posedge clk_i);
    end
    start_i <= 1;
    set_sel_i <= t.sel;
    slot_i <= t.slot;
    weight_i <= t.weight;
    red_i <= t.red;
    green_i <= t.green;
    blue_i <= t.blue;
    sig_empty_i <= t.empty;
    last_i <= t.last;
    do @(posedge clk_i); while (busy_o);
    sb.note_beat(t);
  endtask

  task automatic set_threshold(bit [15:0] v);
    start_i <= 0;
    while (sb.expected_q.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
    while (busy_o) @(posedge clk_i);
    cfg_we_i <= 1;
    cfg_wdata_i <= v;
    @(posedge clk_i);
    cfg_we_i <= 0;
    sb.threshold = v;
  endtask

  function automatic bit [15:0] nudge(bit [15:0] base);
    int v;
    v = int'(base) + int'($urandom_range(0, 4000)) - 2000;
    if (v < 0) v = 0;
    if (v > 65535) v = 65535;
    return 16'(v);
  endfunction

  // one full load of both signatures from a small palette, last on the final beat
  task automatic load_pair();
    bit [15:0] pal[4][3];
    beat_t     t;
    int        order[16];
    int        k, tmp;
    foreach (pal[i, c]) pal[i][c] = 16'($urandom_range(0, 65535));
    for (int i = 0; i < 16; i++) order[i] = i;
    for (int i = 15; i > 0; i--) begin
      k = int'($urandom_range(0, i));
      tmp = order[i];
      order[i] = order[k];
      order[k] = tmp;
    end
    for (int i = 0; i < 16; i++) begin
      k = int'($urandom_range(0, 3));
      t.sel = 1'(order[i] / 8);
      t.slot = 3'(order[i] % 8);
      t.weight = ($urandom_range(0, 19) == 0) ? 16'd0 : 16'($urandom_range(0, 65535));
      t.red = nudge(pal[k][0]);
      t.green = nudge(pal[k][1]);
      t.blue = nudge(pal[k][2]);
      if ($urandom_range(0, 9) == 0) begin
        t.red = 16'($urandom_range(0, 65535));
        t.blue = 16'($urandom_range(0, 65535));
      end
      if ($urandom_range(0, 19) == 0) {t.red, t.green, t.blue} = 0;
      t.empty = ($urandom_range(0, 29) == 0);
      t.last = (i == 15);
      send(t);
    end
  endtask

  task automatic noise_beat();
    beat_t t;
    t.sel = 1'($urandom_range(0, 1));
    t.slot = 3'($urandom_range(0, 7));
    t.weight = 16'($urandom_range(0, 65535));
    t.red = 16'($urandom_range(0, 65535));
    t.green = 16'($urandom_range(0, 65535));
    t.blue = 16'($urandom_range(0, 65535));
    t.empty = ($urandom_range(0, 3) == 0);
    t.last = ($urandom_range(0, 3) == 0);
    send(t);
  endtask

  initial begin
    beat_t     t;
    bit [15:0] thr_list[6];
    repeat (8) @(posedge clk_i);
    rst_ni <= 1;
    @(posedge clk_i);

    // extremes: alternate full-scale and zero entries in both signatures
    for (int i = 0; i < 16; i++) begin
      t.sel = 1'(i / 8);
      t.slot = 3'(i % 8);
      t.weight = (i % 3 == 0) ? 16'hffff : (i % 3 == 1 ? 16'h0000 : 16'h1234);
      t.red = (i % 2) ? 16'hffff : 16'h0000;
      t.green = (i % 4 < 2) ? 16'hffff : 16'h0000;
      t.blue = (i % 5 == 0) ? 16'h0000 : 16'hffff;
      t.empty = 0;
      t.last = (i == 15);
      send(t);
    end
    // last on an A beat, and empty flags on each side
    t = '{0, 7, 16'h8000, 16'h0100, 16'h0200, 16'h0300, 0, 1};
    send(t);
    t.empty = 1;
    send(t);
    t.empty = 0;
    send(t);
    t = '{1, 0, 16'h4000, 16'h0100, 16'h0200, 16'h0300, 1, 1};
    send(t);
    t.empty = 0;
    send(t);
    // zero total on A
    for (int i = 0; i < 8; i++) begin
      t = '{0, 3'(i), 16'h0000, 16'h0100, 16'h0100, 16'h0100, 0, i == 7};
      send(t);
    end

    thr_list = '{16'd0, 16'hffff, 16'd6554, 16'($urandom_range(1, 65534)), 16'd30000,
                 16'd1};
    foreach (thr_list[p]) begin
      set_threshold(thr_list[p]);
      for (int g = 0; g < 16; g++) begin
        load_pair();
        if ($urandom_range(0, 1)) repeat ($urandom_range(1, 4)) noise_beat();
      end
    end

    start_i <= 0;
    while (sb.expected_q.size() != 0) @(posedge clk_i);
    repeat (20) @(posedge clk_i);
    if (sb.errors == 0 && sb.expected_q.size() == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end
endmodule

>>> files.f
hw/rtl/css_pkg.sv
hw/rtl/css_isqrt.sv
hw/rtl/css_front.sv
hw/rtl/css_back.sv
hw/rtl/color_signature_similarity_unit.sv
bench/tb_color_signature_similarity_unit.sv
